// ----- hdl/nlhi_pkg.sv -----
package nlhi_pkg;

    localparam int unsigned LEVEL_W = 11;
    localparam int unsigned RUN_W   = 4;
    localparam int unsigned ANGLE_W = 8;
    localparam int unsigned CLASS_W = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 11;

    localparam logic [CLASS_W-1:0] CLS_QUIET  = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_MEDIUM = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_HIGH   = 2'd2;

    localparam logic [ANGLE_W-1:0] ANGLE_QUIET  = 8'd0;
    localparam logic [ANGLE_W-1:0] ANGLE_MEDIUM = 8'd45;
    localparam logic [ANGLE_W-1:0] ANGLE_HIGH   = 8'd90;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX    = 8'd180;

    localparam logic [RUN_W-1:0] RUN_MAX = 4'd15;

    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_TO_MEDIUM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_TO_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_TO_QUIET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_TO_MEDIUM = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_COUNT  = 3'd5;

    localparam logic              MODE_MEASURE = 1'b0;
    localparam logic              MODE_TICK    = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [LEVEL_W-1:0] noise_level;
    } t_in;

    typedef struct packed {
        logic [CLASS_W-1:0] noise_class;
        logic [ANGLE_W-1:0] pointer_angle;
        logic               class_changed;
        logic               at_target;
    } t_out;

    typedef struct packed {
        logic [LEVEL_W-1:0] floor_level;
        logic [LEVEL_W-1:0] rise_to_medium;
        logic [LEVEL_W-1:0] rise_to_high;
        logic [LEVEL_W-1:0] fall_to_quiet;
        logic [LEVEL_W-1:0] fall_to_medium;
        logic [RUN_W-1:0]   confirm_count;
    } t_cfg;

    function automatic logic [ANGLE_W-1:0] target_of(input logic [CLASS_W-1:0] cls);
        logic [ANGLE_W-1:0] tgt;
        case (cls)
            CLS_MEDIUM: tgt = ANGLE_MEDIUM;
            CLS_HIGH:   tgt = ANGLE_HIGH;
            default:    tgt = ANGLE_QUIET;
        endcase
        return tgt;
    endfunction

endpackage

// ----- hdl/nlhi_cfg.sv -----
module nlhi_cfg
    import nlhi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.floor_level    <= 11'd0;
            r_cfg.rise_to_medium <= 11'd112;
            r_cfg.rise_to_high   <= 11'd224;
            r_cfg.fall_to_quiet  <= 11'd64;
            r_cfg.fall_to_medium <= 11'd160;
            r_cfg.confirm_count  <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FLOOR:          r_cfg.floor_level    <= i_cfg_data[LEVEL_W-1:0];
                CFG_RISE_TO_MEDIUM: r_cfg.rise_to_medium <= i_cfg_data[LEVEL_W-1:0];
                CFG_RISE_TO_HIGH:   r_cfg.rise_to_high   <= i_cfg_data[LEVEL_W-1:0];
                CFG_FALL_TO_QUIET:  r_cfg.fall_to_quiet  <= i_cfg_data[LEVEL_W-1:0];
                CFG_FALL_TO_MEDIUM: r_cfg.fall_to_medium <= i_cfg_data[LEVEL_W-1:0];
                CFG_CONFIRM_COUNT:  r_cfg.confirm_count  <= i_cfg_data[RUN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/nlhi_core.sv -----
module nlhi_core
    import nlhi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_fire,
    input  t_in  i_in,
    output t_out o_res
);

    logic [CLASS_W-1:0] r_class;
    logic [CLASS_W-1:0] r_pend;
    logic [RUN_W-1:0]   r_run;
    logic [ANGLE_W-1:0] r_angle;

    logic [CLASS_W-1:0] n_class;
    logic [CLASS_W-1:0] n_pend;
    logic [RUN_W-1:0]   n_run;
    logic [ANGLE_W-1:0] n_angle;

    logic [LEVEL_W-1:0] rel;
    logic [CLASS_W-1:0] cand;
    logic [RUN_W-1:0]   run_inc;
    logic [ANGLE_W-1:0] tgt;
    logic [ANGLE_W-1:0] diff;
    logic [ANGLE_W-1:0] step;
    logic               changed;

    always_comb begin
        rel = (i_in.noise_level > i_cfg.floor_level) ?
              i_in.noise_level - i_cfg.floor_level : '0;

        case (r_class)
            CLS_QUIET: begin
                if (rel >= i_cfg.rise_to_high)        cand = CLS_HIGH;
                else if (rel >= i_cfg.rise_to_medium) cand = CLS_MEDIUM;
                else                                  cand = CLS_QUIET;
            end
            CLS_MEDIUM: begin
                if (rel >= i_cfg.rise_to_high)        cand = CLS_HIGH;
                else if (rel <= i_cfg.fall_to_quiet)  cand = CLS_QUIET;
                else                                  cand = CLS_MEDIUM;
            end
            CLS_HIGH: begin
                if (rel <= i_cfg.fall_to_medium) begin
                    if (rel <= i_cfg.fall_to_quiet)   cand = CLS_QUIET;
                    else                              cand = CLS_MEDIUM;
                end else begin
                    cand = CLS_HIGH;
                end
            end
            default: cand = CLS_QUIET;
        endcase

        tgt  = target_of(r_class);
        diff = (r_angle > tgt) ? r_angle - tgt : tgt - r_angle;
        step = (r_angle < tgt) ? r_angle + 8'd1 : r_angle - 8'd1;

        n_class = r_class;
        n_pend  = r_pend;
        n_run   = r_run;
        n_angle = r_angle;
        run_inc = r_run;
        changed = 1'b0;

        if (i_in.mode == MODE_MEASURE) begin
            if (cand == r_class) begin
                n_pend = cand;
                n_run  = '0;
            end else begin
                if (cand == r_pend) begin
                    run_inc = (r_run == RUN_MAX) ? r_run : r_run + 4'd1;
                end else begin
                    n_pend  = cand;
                    run_inc = 4'd1;
                end
                if (run_inc >= i_cfg.confirm_count) begin
                    n_class = cand;
                    n_run   = '0;
                    changed = 1'b1;
                end else begin
                    n_run = run_inc;
                end
            end
        end else begin
            if (diff <= 8'd1) begin
                n_angle = tgt;
            end else if (step > ANGLE_MAX) begin
                n_angle = ANGLE_MAX;
            end else begin
                n_angle = step;
            end
        end

        o_res.noise_class   = n_class;
        o_res.pointer_angle = n_angle;
        o_res.class_changed = changed;
        o_res.at_target     = (n_angle == target_of(n_class));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class <= CLS_QUIET;
            r_pend  <= CLS_QUIET;
            r_run   <= '0;
            r_angle <= ANGLE_QUIET;
        end else if (i_fire) begin
            r_class <= n_class;
            r_pend  <= n_pend;
            r_run   <= n_run;
            r_angle <= n_angle;
        end
    end

endmodule

// ----- hdl/nlhi_obuf.sv -----
module nlhi_obuf
    import nlhi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_out i_res,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_res
);

    logic r_out_valid;
    logic r_skid_valid;
    t_out r_out;
    t_out r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_fire;
            end
        end else if (i_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_fire) begin
            r_skid <= i_res;
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

// ----- hdl/noise_level_hysteresis_indicator.sv -----
// A result transaction is registered in the output buffer before it is offered.
// Throughput: one transaction per cycle while not back-pressured; the class and
// pointer update is a single combinational pass into state and result registers.
// A two-entry output buffer keeps input accepted while one result waits.
// Reset is synchronous and active low; it restores the default thresholds,
// quiet class, zero pointer angle and empty output buffer.
module noise_level_hysteresis_indicator
    import nlhi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out
);

    t_cfg cfg;
    t_out res;
    logic in_fire;

    assign in_fire = i_in_valid && o_in_ready;

    nlhi_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    nlhi_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_fire  (in_fire),
        .i_in    (i_in),
        .o_res   (res)
    );

    nlhi_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (in_fire),
        .i_res   (res),
        .o_ready (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (o_out)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
    import nlhi_pkg::*;

    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned RANDOM_ITEMS = 150;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  o_in_ready;
    t_in                   in_item = '0;
    logic                  o_out_valid;
    logic                  out_ready = 1'b0;
    t_out                  o_out;

    t_in  pending_items[$];
    t_out expected_readings[$];
    int unsigned mismatches = 0;
    int unsigned stall_cycles = 0;
    bit steady = 1'b0;

    t_cfg thresholds = '{floor_level: 11'd0, rise_to_medium: 11'd112, rise_to_high: 11'd224,
                         fall_to_quiet: 11'd64, fall_to_medium: 11'd160, confirm_count: 4'd1};
    logic [CLASS_W-1:0] meter_class = CLS_QUIET;
    logic [CLASS_W-1:0] cand_class = CLS_QUIET;
    logic [RUN_W-1:0]   cand_run = '0;
    logic [ANGLE_W-1:0] meter_angle = '0;

    noise_level_hysteresis_indicator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out      (o_out)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [ANGLE_W-1:0] pointer_goal(logic [CLASS_W-1:0] cls);
        logic [ANGLE_W-1:0] goal;
        case (cls)
            CLS_MEDIUM: goal = ANGLE_MEDIUM;
            CLS_HIGH:   goal = ANGLE_HIGH;
            default:    goal = ANGLE_QUIET;
        endcase
        return goal;
    endfunction

    function automatic t_out predict_reading(t_in it);
        logic [LEVEL_W-1:0] rel;
        logic [CLASS_W-1:0] cand;
        logic [ANGLE_W-1:0] goal;
        logic [ANGLE_W-1:0] gap;
        logic               changed;
        t_out               r;
        changed = 1'b0;
        if (it.mode == MODE_MEASURE) begin
            rel = (it.noise_level > thresholds.floor_level) ?
                  it.noise_level - thresholds.floor_level : '0;
            case (meter_class)
                CLS_QUIET: begin
                    if (rel >= thresholds.rise_to_high) cand = CLS_HIGH;
                    else if (rel >= thresholds.rise_to_medium) cand = CLS_MEDIUM;
                    else cand = CLS_QUIET;
                end
                CLS_MEDIUM: begin
                    if (rel >= thresholds.rise_to_high) cand = CLS_HIGH;
                    else if (rel <= thresholds.fall_to_quiet) cand = CLS_QUIET;
                    else cand = CLS_MEDIUM;
                end
                CLS_HIGH: begin
                    if (rel <= thresholds.fall_to_medium) begin
                        if (rel <= thresholds.fall_to_quiet) cand = CLS_QUIET;
                        else cand = CLS_MEDIUM;
                    end else begin
                        cand = CLS_HIGH;
                    end
                end
                default: cand = CLS_QUIET;
            endcase
            if (cand == meter_class) begin
                cand_class = cand;
                cand_run = '0;
            end else begin
                if (cand == cand_class) begin
                    if (cand_run != RUN_MAX) cand_run = cand_run + 1'b1;
                end else begin
                    cand_class = cand;
                    cand_run = 4'd1;
                end
                if (cand_run >= thresholds.confirm_count) begin
                    meter_class = cand;
                    cand_run = '0;
                    changed = 1'b1;
                end
            end
        end else begin
            goal = pointer_goal(meter_class);
            gap = (meter_angle > goal) ? meter_angle - goal : goal - meter_angle;
            if (gap <= 8'd1) meter_angle = goal;
            else if (meter_angle < goal) meter_angle = meter_angle + 1'b1;
            else meter_angle = meter_angle - 1'b1;
            if (meter_angle > ANGLE_MAX) meter_angle = ANGLE_MAX;
        end
        r.noise_class = meter_class;
        r.pointer_angle = meter_angle;
        r.class_changed = changed;
        r.at_target = (meter_angle == pointer_goal(meter_class));
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                expected_readings.push_back(predict_reading(in_item));
            end
            if (!in_valid || o_in_ready) begin
                if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 23)) begin
                    in_item <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_readings.size() == 0) begin
                    $display("%0t: unexpected result transaction %p", $time, o_out);
                    mismatches++;
                end else begin
                    want = expected_readings.pop_front();
                    if (o_out.noise_class !== want.noise_class) begin
                        $display("%0t: noise_class expected %0d actual %0d",
                                 $time, want.noise_class, o_out.noise_class);
                        mismatches++;
                    end
                    if (o_out.pointer_angle !== want.pointer_angle) begin
                        $display("%0t: pointer_angle expected %0d actual %0d",
                                 $time, want.pointer_angle, o_out.pointer_angle);
                        mismatches++;
                    end
                    if (o_out.class_changed !== want.class_changed) begin
                        $display("%0t: class_changed expected %0d actual %0d",
                                 $time, want.class_changed, o_out.class_changed);
                        mismatches++;
                    end
                    if (o_out.at_target !== want.at_target) begin
                        $display("%0t: at_target expected %0d actual %0d",
                                 $time, want.at_target, o_out.at_target);
                        mismatches++;
                    end
                end
            end
            out_ready <= steady || ($urandom_range(99) >= 23);
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic add_item(logic m, logic [LEVEL_W-1:0] lvl);
        t_in x;
        x.mode = m;
        x.noise_level = lvl;
        pending_items.push_back(x);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
    endtask

    task automatic apply_thresholds(t_cfg s);
        write_reg(CFG_FLOOR, s.floor_level);
        write_reg(CFG_RISE_TO_MEDIUM, s.rise_to_medium);
        write_reg(CFG_RISE_TO_HIGH, s.rise_to_high);
        write_reg(CFG_FALL_TO_QUIET, s.fall_to_quiet);
        write_reg(CFG_FALL_TO_MEDIUM, s.fall_to_medium);
        write_reg(CFG_CONFIRM_COUNT, {{(CFG_DATA_W-RUN_W){1'b0}}, s.confirm_count});
        @(posedge i_clk);
        cfg_we <= 1'b0;
        thresholds = s;
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (pending_items.size() != 0 || in_valid || expected_readings.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [LEVEL_W-1:0] pick_level();
        int base;
        int lvl;
        case ($urandom_range(6))
            0: base = 0;
            1: base = int'(thresholds.rise_to_medium);
            2: base = int'(thresholds.rise_to_high);
            3: base = int'(thresholds.fall_to_quiet);
            4: base = int'(thresholds.fall_to_medium);
            default: return LEVEL_W'($urandom_range(2047));
        endcase
        lvl = int'(thresholds.floor_level) + base + int'($urandom_range(4)) - 2;
        if (lvl < 0) lvl = 0;
        if (lvl > 2047) lvl = 2047;
        return lvl[LEVEL_W-1:0];
    endfunction

    // Bursts of equal measurements let the confirmation count be reached, and
    // tick bursts of up to 50 items step the pointer toward its target.
    task automatic queue_random(int unsigned n);
        int unsigned added;
        int unsigned len;
        logic [LEVEL_W-1:0] lvl;
        added = 0;
        while (added < n) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    len = $urandom_range(50, 1);
                    repeat (len) add_item(MODE_TICK, LEVEL_W'($urandom_range(2047)));
                end
                9: begin
                    len = 1;
                    add_item(MODE_MEASURE, LEVEL_W'($urandom_range(2047)));
                end
                default: begin
                    lvl = pick_level();
                    len = $urandom_range(thresholds.confirm_count + 2, 1);
                    repeat (len) add_item(MODE_MEASURE, lvl);
                end
            endcase
            added += len;
        end
    endtask

    initial begin
        t_cfg plan[8];
        plan[0] = '{11'd0, 11'd112, 11'd224, 11'd64, 11'd160, 4'd3};
        plan[1] = '{11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 4'd0};
        plan[2] = '{11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 4'd15};
        plan[3] = '{11'd300, 11'd50, 11'd100, 11'd30, 11'd80, 4'd2};
        plan[4] = '{11'd100, 11'd200, 11'd150, 11'd250, 11'd50, 4'd5};
        plan[5].floor_level = LEVEL_W'($urandom_range(600));
        plan[5].fall_to_quiet = LEVEL_W'($urandom_range(300));
        plan[5].rise_to_medium = LEVEL_W'(plan[5].fall_to_quiet + $urandom_range(300, 1));
        plan[5].fall_to_medium = LEVEL_W'(plan[5].rise_to_medium + $urandom_range(300));
        plan[5].rise_to_high = LEVEL_W'(plan[5].fall_to_medium + $urandom_range(300, 1));
        plan[5].confirm_count = RUN_W'($urandom_range(15, 1));
        plan[6] = '{LEVEL_W'($urandom_range(2047)), LEVEL_W'($urandom_range(2047)),
                    LEVEL_W'($urandom_range(2047)), LEVEL_W'($urandom_range(2047)),
                    LEVEL_W'($urandom_range(2047)), RUN_W'($urandom_range(15))};
        plan[7] = '{11'd16, 11'd96, 11'd200, 11'd48, 11'd140, 4'd1};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_item(MODE_MEASURE, 11'd0);
        add_item(MODE_TICK, 11'd0);
        add_item(MODE_MEASURE, 11'd2047);
        repeat (3) add_item(MODE_TICK, 11'd0);
        add_item(MODE_MEASURE, 11'd224);
        add_item(MODE_MEASURE, 11'd160);
        add_item(MODE_MEASURE, 11'd161);
        add_item(MODE_MEASURE, 11'd64);
        add_item(MODE_MEASURE, 11'd111);
        add_item(MODE_MEASURE, 11'd112);
        add_item(MODE_TICK, 11'd2047);
        add_item(MODE_MEASURE, 11'd223);
        add_item(MODE_MEASURE, 11'd224);
        add_item(MODE_MEASURE, 11'd65);
        add_item(MODE_MEASURE, 11'd2047);
        repeat (2) add_item(MODE_TICK, 11'd1365);
        queue_random(RANDOM_ITEMS);
        drain();

        foreach (plan[p]) begin
            steady = (p == 0);
            apply_thresholds(plan[p]);
            queue_random(RANDOM_ITEMS);
            drain();
        end

        if (mismatches == 0 && expected_readings.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/nlhi_pkg.sv
hdl/nlhi_cfg.sv
hdl/nlhi_core.sv
hdl/nlhi_obuf.sv
hdl/noise_level_hysteresis_indicator.sv
tb/sv/tb_top.sv
